// File: rtl/epoch_seconds_to_calendar_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar block
// Clocked concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Check on every rising clk edge, muted while rst is high
`define ESTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising clk edge, reset cycles included
`define ESTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/estc_pkg.sv
// ----------------------------------------------------------------------------
// estc_pkg
// Shared constants, types and the month length table for the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package estc_pkg;

  // Calendar and time constants
  localparam int unsigned BASE_YEAR     = 1970;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_4YR  = 1461;
  localparam int unsigned DAYS_LEAP     = 366;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned EPOCH_WEEKDAY = 4;  // first day of the count is a Thursday
  localparam int unsigned LAST_MONTH    = 11; // December, counted from zero
  // From this year on the two-digit-year weekday formula runs one day ahead
  // of the plain day count, since its century offset repeats that of 2000
  localparam int unsigned CENTURY_YEAR  = 2100;

  // Width of the shared subtractor
  localparam int unsigned SUB_W = 18;

  // Result of the shared subtractor
  typedef struct packed {
    logic             ge;    // a >= b
    logic [SUB_W-1:0] diff;  // a - b
  } sub_res_t;

  // Month lengths of a common year, January first
  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of month mon (0 = January), February stretched in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (mon <= 4'(LAST_MONTH)) begin
      len = MONTH_DAYS[mon];
    end
    if (mon == 4'd1 && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit count of seconds since the start of 1970 into year,
// month, day, hour, minute, second and day of week.
// ----------------------------------------------------------------------------
// Pulse start with a word on seconds_count while busy is low; busy then stays
// high until the result is out. The result shows on the output ports for one
// cycle marked by done and must be captured then, since it cannot be held
// back. The split into days, the year walk (four years at a time, then single
// years), the month walk and the hours and minutes all share one 18-bit
// subtractor, one step per cycle, before a last step puts the word out.
// Leap years are every fourth year, so dates are exact through 2099.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar #(
  parameter int unsigned BASE_YEAR = estc_pkg::BASE_YEAR
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] seconds_count,
  output logic             busy,
  output logic             done,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [2:0]       weekday
);

  localparam int unsigned W = estc_pkg::SUB_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DAYS   = 8'b0000_0010,
    S_YEAR4  = 8'b0000_0100,
    S_YEAR1  = 8'b0000_1000,
    S_MONTH  = 8'b0001_0000,
    S_HOUR   = 8'b0010_0000,
    S_MINUTE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [31:0]         sec_sh;
  logic [16:0]         rem;
  logic [15:0]         days;
  logic [11:0]         yr;
  logic [3:0]          mon;
  logic [4:0]          hr;
  logic [5:0]          mnt;
  logic [2:0]          wk;
  logic [4:0]          cnt;

  logic [W-1:0]        op_a;
  logic [W-1:0]        op_b;
  estc_pkg::sub_res_t  res;
  logic                leap;
  logic                late_century;
  logic [3:0]          wk_dbl;
  logic [2:0]          wk_next;
  logic [3:0]          wk_sum;
  logic [2:0]          wk_fin;

  assign busy = (state != S_IDLE);
  assign leap = (yr[1:0] == 2'b00);
  assign late_century = (yr >= 12'(estc_pkg::CENTURY_YEAR));

  // Select operands of the shared subtractor for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_DAYS: begin
        op_a = {rem, sec_sh[31]};
        op_b = W'(estc_pkg::SECS_PER_DAY);
      end
      S_YEAR4: begin
        op_a = W'(days);
        op_b = W'(estc_pkg::DAYS_PER_4YR);
      end
      S_YEAR1: begin
        op_a = W'(days);
        op_b = leap ? W'(estc_pkg::DAYS_LEAP) : W'(estc_pkg::DAYS_COMMON);
      end
      S_MONTH: begin
        op_a = W'(days);
        op_b = W'(estc_pkg::month_len(mon, leap));
      end
      S_HOUR: begin
        op_a = W'(rem);
        op_b = W'(estc_pkg::SECS_PER_HOUR) << cnt[2:0];
      end
      S_MINUTE: begin
        op_a = W'(rem);
        op_b = W'(estc_pkg::SECS_PER_MIN) << cnt[2:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  estc_sub u_sub (
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  // Track the day count modulo 7 as quotient bits arrive; advance one day
  // from 2100 on to follow the two-digit-year weekday formula
  always_comb begin
    wk_dbl  = {wk, res.ge};
    wk_next = (wk_dbl >= 4'd7) ? 3'(wk_dbl - 4'd7) : wk_dbl[2:0];
    wk_sum  = {1'b0, wk} + 4'(estc_pkg::EPOCH_WEEKDAY) + {3'b000, late_century};
    wk_fin  = (wk_sum >= 4'd7) ? 3'(wk_sum - 4'd7) : wk_sum[2:0];
  end

  // Sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            sec_sh <= seconds_count;
            rem    <= '0;
            days   <= '0;
            wk     <= '0;
            yr     <= 12'(BASE_YEAR);
            mon    <= '0;
            hr     <= '0;
            mnt    <= '0;
            cnt    <= 5'd31;
            state  <= S_DAYS;
          end
        end
        // Long division by seconds per day, one bit per cycle
        S_DAYS: begin
          sec_sh <= {sec_sh[30:0], 1'b0};
          rem    <= res.ge ? res.diff[16:0] : op_a[16:0];
          days   <= {days[14:0], res.ge};
          wk     <= wk_next;
          cnt    <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_YEAR4;
          end
        end
        // Drop whole four-year blocks
        S_YEAR4: begin
          if (res.ge) begin
            days <= res.diff[15:0];
            yr   <= yr + 12'd4;
          end else begin
            state <= S_YEAR1;
          end
        end
        // Drop single years
        S_YEAR1: begin
          if (res.ge) begin
            days <= res.diff[15:0];
            yr   <= yr + 12'd1;
          end else begin
            state <= S_MONTH;
          end
        end
        // Walk months; December takes whatever is left
        S_MONTH: begin
          if (res.ge && mon != 4'(estc_pkg::LAST_MONTH)) begin
            days <= res.diff[15:0];
            mon  <= mon + 4'd1;
          end else begin
            cnt   <= 5'd4;
            state <= S_HOUR;
          end
        end
        // Hours by shifted divisor, five quotient bits
        S_HOUR: begin
          if (res.ge) begin
            rem <= res.diff[16:0];
          end
          hr <= {hr[3:0], res.ge};
          if (cnt == 5'd0) begin
            cnt   <= 5'd5;
            state <= S_MINUTE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        // Minutes by shifted divisor, six quotient bits
        S_MINUTE: begin
          if (res.ge) begin
            rem <= res.diff[16:0];
          end
          mnt <= {mnt[4:0], res.ge};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_DONE;
          end
        end
        // Load the output word and return to idle
        S_DONE: begin
          year    <= yr;
          month   <= mon + 4'd1;
          day     <= days[4:0] + 5'd1;
          hour    <= hr;
          minute  <= mnt;
          second  <= rem[5:0];
          weekday <= wk_fin;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/estc_sub.sv
// ----------------------------------------------------------------------------
// estc_sub
// Shared subtract and compare unit used by every arithmetic step of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module estc_sub (
  input  wire logic [estc_pkg::SUB_W-1:0] a,
  input  wire logic [estc_pkg::SUB_W-1:0] b,
  output estc_pkg::sub_res_t              res
);

  logic [estc_pkg::SUB_W:0] diff_full;

  // Subtract with one extra bit; no borrow means a >= b
  assign diff_full = {1'b0, a} - {1'b0, b};
  assign res.ge    = ~diff_full[estc_pkg::SUB_W];
  assign res.diff  = diff_full[estc_pkg::SUB_W-1:0];

endmodule

`default_nettype wire

// File: rtl/estc_chk.sv
// ----------------------------------------------------------------------------
// estc_chk
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_calendar_macros.svh"

module estc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic [31:0] seconds_count,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [11:0] year,
  input wire logic [3:0]  month,
  input wire logic [4:0]  day,
  input wire logic [4:0]  hour,
  input wire logic [5:0]  minute,
  input wire logic [5:0]  second,
  input wire logic [2:0]  weekday
);

  logic accept;
  logic fields_ok;

  assign accept    = start && !busy;
  assign fields_ok = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
                     (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59) &&
                     (weekday <= 3'd6);

  // Reset leaves the block idle with no word out
  `ESTC_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")
  // An accepted word keeps the block busy
  `ESTC_ASSERT(a_accept_busy, accept |=> busy, "accepted word did not raise busy")
  // The word goes out only once the block is ready again
  `ESTC_ASSERT(a_done_idle, done |-> !busy, "done while still busy")
  // A word lasts one cycle and a second word needs a new start
  `ESTC_ASSERT(a_done_pulse, done |=> !done, "done held longer than one cycle")
  // Every field of an output word but the year is in range; day is checked from below only
  `ESTC_ASSERT(a_fields, done |-> fields_ok, "output field out of range")

endmodule

bind epoch_seconds_to_calendar estc_chk u_estc_chk (.*);

`default_nettype wire

// File: bench/epoch_seconds_to_calendar_test.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Self-checking bench for the seconds to calendar converter. Sends second
// counts through the start/busy handshake with random gaps, predicts each
// date, time and day of week in the bench, and checks every done strobe
// against the oldest outstanding prediction. Covers range ends, day and year
// boundaries, leap days, the 2100 leap quirk and a long random run.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIRST_YEAR     = 1970;
  localparam int unsigned DAY_SECS       = 86400;
  localparam int unsigned HOUR_SECS      = 3600;
  localparam int unsigned LAST_DAY_INDEX = 49710;   // day that holds 32'hFFFFFFFF
  localparam int unsigned RANDOM_WORDS   = 1000;
  localparam int unsigned DRAIN_CYCLES   = 120;      // longest conversion plus margin
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  // Month lengths of a common year and the day of week month offsets
  localparam int unsigned MONTH_LENGTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned MONTH_SHIFT  [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] seconds_count;
  logic        busy;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  calendar_t   pending_dates [$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned dates_checked;
  int unsigned cycle_count;
  int unsigned max_gap;

  epoch_seconds_to_calendar u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .seconds_count (seconds_count),
    .busy          (busy),
    .done          (done),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .weekday       (weekday)
  );

  // Free-running clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the calendar fields for one second count
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    int unsigned hi;
    int unsigned lo;
    int unsigned t;
    days = secs / DAY_SECS;
    rem  = secs % DAY_SECS;
    yr   = FIRST_YEAR;
    mon  = 0;
    // Walk whole years; every fourth year counts 366 days
    forever begin
      len = (yr % 4 == 0) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    // Walk months up to December
    while (mon < 11) begin
      len = MONTH_LENGTH[mon];
      if (mon == 1 && yr % 4 == 0) len = 29;
      if (days < len) break;
      days -= len;
      mon++;
    end
    // Day of week from the month offset formula
    hi = yr / 100;
    lo = yr % 100;
    if (hi > 19) lo += 100;
    t = (lo + lo / 4) % 7;
    t = t + days + 1 + MONTH_SHIFT[mon];
    if (lo % 4 == 0 && mon < 2) t -= 1;
    cal.year    = 12'(yr);
    cal.month   = 4'(mon + 1);
    cal.day     = 5'(days + 1);
    cal.hour    = 5'(rem / HOUR_SECS);
    cal.minute  = 6'((rem % HOUR_SECS) / 60);
    cal.second  = 6'(rem % 60);
    cal.weekday = 3'(t % 7);
    return cal;
  endfunction

  // Print one mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Send one word: idle for a random gap, then hold start until accepted
  task automatic send_seconds(input logic [31:0] secs);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      // Half the time let the block go idle first so gaps land there too
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    seconds_count <= secs;
    do @(posedge clk); while (busy);
    pending_dates.push_back(calendar_of(secs));
    words_sent++;
  endtask

  // Drop start and wait until every outstanding date has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Check each done strobe against the oldest prediction
  always @(posedge clk) begin
    calendar_t want;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("done with no word outstanding");
      end else begin
        want = pending_dates.pop_front();
        dates_checked++;
        if (year !== want.year)
          report_mismatch($sformatf("year %0d, want %0d", year, want.year));
        if (month !== want.month)
          report_mismatch($sformatf("month %0d, want %0d", month, want.month));
        if (day !== want.day)
          report_mismatch($sformatf("day %0d, want %0d", day, want.day));
        if (hour !== want.hour)
          report_mismatch($sformatf("hour %0d, want %0d", hour, want.hour));
        if (minute !== want.minute)
          report_mismatch($sformatf("minute %0d, want %0d", minute, want.minute));
        if (second !== want.second)
          report_mismatch($sformatf("second %0d, want %0d", second, want.second));
        if (weekday !== want.weekday)
          report_mismatch($sformatf("weekday %0d, want %0d", weekday, want.weekday));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Range ends, day edges and the year 2038 signed wrap point
  task automatic test_range_edges();
    logic [31:0] words [$];
    words = '{32'd0, 32'd1, 32'd59, 32'd86399, 32'd86400, 32'd31535999,
              32'd2147483647, 32'd2147483648, 32'hFFFFFFFE, 32'hFFFFFFFF};
    foreach (words[i]) send_seconds(words[i]);
    drain_results();
  endtask

  // Leap days and the last day of a leap year, which stays in that year
  task automatic test_leap_days();
    logic [31:0] words [$];
    words = '{32'd68169600, 32'd94521600, 32'd94607999, 32'd94608000,
              32'd951782400, 32'd978307199, 32'd978307200};
    foreach (words[i]) send_seconds(words[i]);
    drain_results();
  endtask

  // Century years: 2100 counts as a leap year, so dates slip a day after it
  task automatic test_century_quirk();
    logic [31:0] words [$];
    words = '{32'd4102444799, 32'd4102444800, 32'd4107456000, 32'd4107542400,
              32'd4107628800, 32'd4133980799, 32'd4134067200};
    foreach (words[i]) send_seconds(words[i]);
    drain_results();
  endtask

  // Random words: day starts, day ends, random times of a random day and fully
  // random words, with a stretch of back-to-back traffic in the middle
  task automatic test_random_words();
    logic [63:0] pick;
    int unsigned dnum;
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      max_gap = (n >= 400 && n < 550) ? 0 : 18;
      dnum = $urandom_range(0, LAST_DAY_INDEX);
      case ($urandom_range(0, 3))
        0: pick = 64'($urandom);
        1: pick = 64'(dnum) * DAY_SECS;
        2: pick = 64'(dnum) * DAY_SECS + DAY_SECS - 1;
        default: pick = 64'(dnum) * DAY_SECS + $urandom_range(0, DAY_SECS - 1);
      endcase
      if (pick > 64'hFFFFFFFF) pick = 64'($urandom);
      send_seconds(pick[31:0]);
    end
    drain_results();
  endtask

  // Reset, run each test, then report
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    seconds_count = '0;
    error_count   = 0;
    words_sent    = 0;
    dates_checked = 0;
    cycle_count   = 0;
    max_gap       = 18;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_range_edges();
    test_leap_days();
    test_century_quirk();
    test_random_words();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d second counts, checked %0d dates", words_sent, dates_checked);
    $display("Covered range ends, leap days, the 2100 quirk and random day edges");
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
